// File: hw/rtl/bsra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bsra_pkg
// Shared types and codes of the banker's safe resource allocator: transaction
// payloads, action and status codes, sequencer states, scan status.
// -----------------------------------------------------------------------------
package bsra_pkg;

   // fixed field widths of the transaction payloads
   localparam int ACTION_W = 3;
   localparam int TASK_W   = 3;
   localparam int RES_W    = 2;
   localparam int UNIT_W   = 16;
   localparam int STATUS_W = 3;

   // action codes; the remaining codes are ignored
   typedef enum logic [ACTION_W-1:0] {
      ACT_LOAD    = 3'd0,
      ACT_CLAIM   = 3'd1,
      ACT_REQUEST = 3'd2,
      ACT_RELEASE = 3'd3,
      ACT_RETIRE  = 3'd4
   } action_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_DONE       = 3'd0,
      ST_BLOCKED    = 3'd1,
      ST_OVER_NEED  = 3'd2,
      ST_OVER_CLAIM = 3'd3,
      ST_RETIRED    = 3'd4
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_EXEC,
      SEQ_SCAN,
      SEQ_GRANT,
      SEQ_REPLY
   } seq_state_type;

   // request transaction
   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [TASK_W-1:0]   task_index;
      logic [RES_W-1:0]    resource_index;
      logic [UNIT_W-1:0]   units;
   } req_type;

   // response transaction
   typedef struct packed {
      status_type        status;
      logic [UNIT_W-1:0] units_free;
   } rsp_type;

   // safety scan status toward the sequencer
   typedef struct packed {
      logic finished;
      logic safe;
   } scan_stat_type;

endpackage
`default_nettype wire

// File: hw/rtl/bsra_row_mem.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bsra_row_mem
// Per-task row memory: claim and held units of every resource in one row.
// One write port, one read port with registered read data. Rows never
// written read as zero through a row valid bit.
// -----------------------------------------------------------------------------
module bsra_row_mem #(
   parameter int TASK_COUNT     = 8,
   parameter int RESOURCE_COUNT = 4,
   parameter int UNIT_BITS      = 16,
   localparam int TASK_AW       = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      wr_en,
   input  wire [TASK_AW-1:0]                        wr_addr,
   input  wire [RESOURCE_COUNT-1:0][UNIT_BITS-1:0]  wr_claim,
   input  wire [RESOURCE_COUNT-1:0][UNIT_BITS-1:0]  wr_held,
   input  wire                                      rd_en,
   input  wire [TASK_AW-1:0]                        rd_addr,
   output logic [RESOURCE_COUNT-1:0][UNIT_BITS-1:0] rd_claim,
   output logic [RESOURCE_COUNT-1:0][UNIT_BITS-1:0] rd_held
);

   logic [1:0][RESOURCE_COUNT-1:0][UNIT_BITS-1:0] row_mem [TASK_COUNT];
   logic [1:0][RESOURCE_COUNT-1:0][UNIT_BITS-1:0] rd_data_ff;
   logic [TASK_COUNT-1:0]                         valid_ff;
   logic [TASK_COUNT-1:0]                         valid_in;
   logic                                          rd_valid_ff;
   logic                                          rd_valid_in;

   // row storage and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         row_mem[wr_addr] <= {wr_claim, wr_held};
      end
      if (rd_en) begin
         rd_data_ff <= row_mem[rd_addr];
      end
   end

   // row valid bits
   always_comb begin
      valid_in    = valid_ff;
      rd_valid_in = rd_valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      if (rd_en) begin
         rd_valid_in = valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   // unwritten rows read as zero
   assign rd_claim = rd_valid_ff ? rd_data_ff[1] : '0;
   assign rd_held  = rd_valid_ff ? rd_data_ff[0] : '0;

endmodule
`default_nettype wire

// File: hw/rtl/bsra_safety_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bsra_safety_scan
// Banker's safety check. Reads one task row per cycle from the row memory
// and compares all resources of that row against the work vector in
// parallel; a task that fits is marked finished and returns its units to
// the work vector. Rows are visited round robin until every task is
// finished (safe) or a full round passes with no task finishing (unsafe).
// -----------------------------------------------------------------------------
module bsra_safety_scan #(
   parameter int TASK_COUNT     = 8,
   parameter int RESOURCE_COUNT = 4,
   parameter int UNIT_BITS      = 16,
   localparam int TASK_AW       = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1,
   localparam int RES_AW        = (RESOURCE_COUNT > 1) ? $clog2(RESOURCE_COUNT) : 1
) (
   input  wire                                      clock,
   input  wire                                      reset,
   input  wire                                      launch,
   input  wire [TASK_AW-1:0]                        grant_task,
   input  wire [RES_AW-1:0]                         grant_res,
   input  wire [UNIT_BITS-1:0]                      grant_units,
   input  wire [RESOURCE_COUNT-1:0][UNIT_BITS-1:0]  free_units,
   input  wire [TASK_COUNT-1:0]                     retired,
   output logic                                     rd_en,
   output logic [TASK_AW-1:0]                       rd_addr,
   input  wire [RESOURCE_COUNT-1:0][UNIT_BITS-1:0]  rd_claim,
   input  wire [RESOURCE_COUNT-1:0][UNIT_BITS-1:0]  rd_held,
   output bsra_pkg::scan_stat_type                  scan_stat
);

   import bsra_pkg::*;

   // work holds free units, less the tentative grant, plus everything returned by finished tasks
   localparam int WORK_W = UNIT_BITS + $clog2(TASK_COUNT + 1);

   logic                                         active_ff, active_in;
   logic [TASK_AW-1:0]                           issue_ff, issue_in;
   logic                                         chk_valid_ff, chk_valid_in;
   logic [TASK_AW-1:0]                           chk_idx_ff, chk_idx_in;
   logic [RESOURCE_COUNT-1:0][WORK_W-1:0]        work_ff, work_in;
   logic [TASK_COUNT-1:0]                        done_ff, done_in;
   logic [TASK_AW-1:0]                           quiet_ff, quiet_in;

   logic [RESOURCE_COUNT-1:0][UNIT_BITS-1:0]     hold_adj;
   logic [RESOURCE_COUNT-1:0][WORK_W-1:0]        work_add;
   logic [TASK_COUNT-1:0]                        done_set;
   logic [TASK_COUNT-1:0]                        done_next;
   logic                                         fits;
   logic                                         eval;
   logic                                         fit;
   logic                                         all_done;
   logic                                         finished;

   // compare one row against the work vector, all resources in parallel
   always_comb begin
      fits     = 1'b1;
      work_add = work_ff;
      for (int r = 0; r < RESOURCE_COUNT; r++) begin
         // the task under test holds its tentative grant
         hold_adj[r] = rd_held[r] +
                       (((chk_idx_ff == grant_task) && (RES_AW'(r) == grant_res)) ?
                        grant_units : '0);
         if (rd_claim[r] > hold_adj[r]) begin
            if (WORK_W'(rd_claim[r] - hold_adj[r]) > work_ff[r]) begin
               fits = 1'b0;
            end
         end
         work_add[r] = work_ff[r] + WORK_W'(hold_adj[r]);
      end
   end

   // round progress and termination
   always_comb begin
      done_set             = '0;
      eval                 = active_ff && chk_valid_ff;
      fit                  = eval && fits && !done_ff[chk_idx_ff];
      done_set[chk_idx_ff] = fit;
      done_next            = done_ff | done_set;
      all_done             = &done_next;
      finished             = eval &&
                             (all_done || (!fit && (quiet_ff == TASK_AW'(TASK_COUNT - 1))));
   end

   // next scan state
   always_comb begin
      active_in    = active_ff;
      issue_in     = issue_ff;
      chk_valid_in = chk_valid_ff;
      chk_idx_in   = chk_idx_ff;
      work_in      = work_ff;
      done_in      = done_ff;
      quiet_in     = quiet_ff;
      if (launch) begin
         active_in    = 1'b1;
         issue_in     = '0;
         chk_valid_in = 1'b0;
         done_in      = retired;
         quiet_in     = '0;
         for (int r = 0; r < RESOURCE_COUNT; r++) begin
            work_in[r] = WORK_W'(free_units[r]) -
                         ((RES_AW'(r) == grant_res) ? WORK_W'(grant_units) : '0);
         end
      end else if (active_ff) begin
         active_in    = !finished;
         chk_valid_in = !finished;
         chk_idx_in   = issue_ff;
         issue_in     = (issue_ff == TASK_AW'(TASK_COUNT - 1)) ? '0 : issue_ff + 1'b1;
         if (eval) begin
            done_in  = done_next;
            work_in  = fit ? work_add : work_ff;
            quiet_in = fit ? '0 : quiet_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         chk_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         chk_valid_ff <= chk_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff   <= issue_in;
      chk_idx_ff <= chk_idx_in;
      work_ff    <= work_in;
      done_ff    <= done_in;
      quiet_ff   <= quiet_in;
   end

   // row fetch and status
   assign rd_en              = active_ff && !finished;
   assign rd_addr            = issue_ff;
   assign scan_stat.finished = finished;
   assign scan_stat.safe     = all_done;

endmodule
`default_nettype wire

// File: hw/rtl/bankers_safe_resource_allocator.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bankers_safe_resource_allocator
// Deadlock-avoiding resource manager built around the banker's safety check.
// -----------------------------------------------------------------------------
// Usage:
//   A transaction is taken on req_payload at a rising edge with start high
//   and busy low. busy stays high until the result has been shown. Every
//   transaction gives one result on rsp_payload, marked by rsp_valid for
//   exactly one cycle; the receiver has no way to hold it off.
//   Load, claim, release, retire, refused and ignored transactions pass
//   through the execute and reply states. A request that passes the need
//   and free checks runs the safety scan, which reads one task row per
//   cycle from the row memory and tests all resources of it at once; rows
//   are revisited until every live task finishes or a full round of
//   TASK_COUNT rows passes with none finishing. A safe scan goes on to the
//   grant state, which commits the grant, and then to the reply state; an
//   unsafe scan replies blocked. The next transaction can be taken at the
//   end of the cycle after the result.
//   Reset clears the free pool, all claims and holdings (through row valid
//   bits) and all retired flags at once; no clearing pass is needed.
// -----------------------------------------------------------------------------
module bankers_safe_resource_allocator #(
   parameter int TASK_COUNT     = 8,
   parameter int RESOURCE_COUNT = 4,
   parameter int UNIT_BITS      = 16
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                start,
   output logic               busy,
   input  wire bsra_pkg::req_type req_payload,
   output logic               rsp_valid,
   output bsra_pkg::rsp_type  rsp_payload
);

   import bsra_pkg::*;

   localparam int TASK_AW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;
   localparam int RES_AW  = (RESOURCE_COUNT > 1) ? $clog2(RESOURCE_COUNT) : 1;

   typedef logic [RESOURCE_COUNT-1:0][UNIT_BITS-1:0] row_type;

   seq_state_type         state_ff, state_in;
   req_type               req_ff, req_in;
   row_type               free_ff, free_in;
   logic [TASK_COUNT-1:0] retired_ff, retired_in;
   status_type            status_ff, status_in;
   row_type               pend_claim_ff, pend_claim_in;
   row_type               pend_held_ff, pend_held_in;

   row_type               rd_claim;
   row_type               rd_held;
   row_type               wr_claim;
   row_type               wr_held;
   row_type               drop_free;
   logic                  mem_we;
   logic                  mem_re;
   logic [TASK_AW-1:0]    mem_rd_addr;

   logic                  scan_launch;
   logic                  scan_rd_en;
   logic [TASK_AW-1:0]    scan_rd_addr;
   scan_stat_type         scan_stat;

   logic                  accept;
   logic                  port_t_ok;
   logic [TASK_AW-1:0]    t_idx;
   logic [RES_AW-1:0]     r_idx;
   logic                  t_ok;
   logic                  r_ok;
   logic [UNIT_BITS-1:0]  u;
   logic [UNIT_BITS-1:0]  cur_free;
   logic [UNIT_BITS-1:0]  cur_claim;
   logic [UNIT_BITS-1:0]  cur_held;
   logic [UNIT_BITS-1:0]  give;
   logic [UNIT_BITS:0]    rel_sum;
   logic [UNIT_BITS:0]    drop_sum;
   logic                  over_need;

   // transaction decode
   assign accept    = start && !busy;
   assign port_t_ok = (32'(req_payload.task_index) < TASK_COUNT);
   assign t_idx     = TASK_AW'(req_ff.task_index);
   assign r_idx     = RES_AW'(req_ff.resource_index);
   assign t_ok      = (32'(req_ff.task_index) < TASK_COUNT);
   assign r_ok      = (32'(req_ff.resource_index) < RESOURCE_COUNT);
   assign u         = UNIT_BITS'(req_ff.units);

   // operands of the addressed task and resource
   always_comb begin
      cur_free  = r_ok ? free_ff[r_idx] : '0;
      cur_claim = r_ok ? rd_claim[r_idx] : '0;
      cur_held  = r_ok ? rd_held[r_idx] : '0;
      over_need = ({1'b0, cur_held} + {1'b0, u}) > {1'b0, cur_claim};
      give      = (u < cur_held) ? u : cur_held;
      rel_sum   = {1'b0, cur_free} + {1'b0, give};
      drop_sum  = '0;
      for (int r = 0; r < RESOURCE_COUNT; r++) begin
         // returned units saturate the free pool
         drop_sum     = {1'b0, free_ff[r]} + {1'b0, rd_held[r]};
         drop_free[r] = drop_sum[UNIT_BITS] ? '1 : drop_sum[UNIT_BITS-1:0];
      end
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               state_in = SEQ_EXEC;
            end
         end
         SEQ_EXEC: begin
            state_in = scan_launch ? SEQ_SCAN : SEQ_REPLY;
         end
         SEQ_SCAN: begin
            if (scan_stat.finished) begin
               state_in = scan_stat.safe ? SEQ_GRANT : SEQ_REPLY;
            end
         end
         SEQ_GRANT: begin
            state_in = SEQ_REPLY;
         end
         SEQ_REPLY: begin
            state_in = SEQ_IDLE;
         end
         default: begin
            state_in = SEQ_IDLE;
         end
      endcase
   end

   // sequencer actions
   always_comb begin
      req_in        = accept ? req_payload : req_ff;
      free_in       = free_ff;
      retired_in    = retired_ff;
      status_in     = status_ff;
      pend_claim_in = pend_claim_ff;
      pend_held_in  = pend_held_ff;
      mem_we        = 1'b0;
      wr_claim      = rd_claim;
      wr_held       = rd_held;
      scan_launch   = 1'b0;
      case (state_ff)
         SEQ_EXEC: begin
            status_in     = ST_DONE;
            pend_claim_in = rd_claim;
            pend_held_in  = rd_held;
            if (!r_ok) begin
               // unknown resource: nothing changes
            end else if (req_ff.action == ACT_LOAD) begin
               free_in[r_idx] = u;
            end else if (t_ok && (req_ff.action inside
                         {ACT_CLAIM, ACT_REQUEST, ACT_RELEASE, ACT_RETIRE})) begin
               if (retired_ff[t_idx]) begin
                  status_in = ST_RETIRED;
               end else begin
                  case (req_ff.action)
                     ACT_CLAIM: begin
                        mem_we = 1'b1;
                        if (u > cur_free) begin
                           // claim larger than the pool: abort
                           free_in           = drop_free;
                           retired_in[t_idx] = 1'b1;
                           wr_held           = '0;
                           status_in         = ST_OVER_CLAIM;
                        end else begin
                           wr_claim[r_idx] = u;
                        end
                     end
                     ACT_REQUEST: begin
                        if (over_need) begin
                           // request beyond remaining need: abort
                           mem_we            = 1'b1;
                           free_in           = drop_free;
                           retired_in[t_idx] = 1'b1;
                           wr_held           = '0;
                           status_in         = ST_OVER_NEED;
                        end else if (u > cur_free) begin
                           status_in = ST_BLOCKED;
                        end else begin
                           scan_launch = 1'b1;
                        end
                     end
                     ACT_RELEASE: begin
                        mem_we         = 1'b1;
                        wr_held[r_idx] = cur_held - give;
                        free_in[r_idx] = rel_sum[UNIT_BITS] ? '1 : rel_sum[UNIT_BITS-1:0];
                     end
                     ACT_RETIRE: begin
                        mem_we            = 1'b1;
                        free_in           = drop_free;
                        retired_in[t_idx] = 1'b1;
                        wr_held           = '0;
                     end
                     default: begin
                     end
                  endcase
               end
            end
         end
         SEQ_SCAN: begin
            if (scan_stat.finished && !scan_stat.safe) begin
               status_in = ST_BLOCKED;
            end
         end
         SEQ_GRANT: begin
            // commit the tentative grant
            mem_we         = 1'b1;
            wr_claim       = pend_claim_ff;
            wr_held        = pend_held_ff;
            wr_held[r_idx] = pend_held_ff[r_idx] + u;
            free_in[r_idx] = free_ff[r_idx] - u;
         end
         default: begin
         end
      endcase
   end

   // control and pool registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= SEQ_IDLE;
         free_ff    <= '0;
         retired_ff <= '0;
      end else begin
         state_ff   <= state_in;
         free_ff    <= free_in;
         retired_ff <= retired_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      status_ff     <= status_in;
      pend_claim_ff <= pend_claim_in;
      pend_held_ff  <= pend_held_in;
   end

   // row memory read port: addressed task on acceptance, scan rows after
   assign mem_re      = (state_ff == SEQ_IDLE && start && port_t_ok) || scan_rd_en;
   assign mem_rd_addr = scan_rd_en ? scan_rd_addr : TASK_AW'(req_payload.task_index);

   bsra_row_mem #(
      .TASK_COUNT     (TASK_COUNT),
      .RESOURCE_COUNT (RESOURCE_COUNT),
      .UNIT_BITS      (UNIT_BITS)
   ) u_row_mem (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (mem_we),
      .wr_addr  (t_idx),
      .wr_claim (wr_claim),
      .wr_held  (wr_held),
      .rd_en    (mem_re),
      .rd_addr  (mem_rd_addr),
      .rd_claim (rd_claim),
      .rd_held  (rd_held)
   );

   bsra_safety_scan #(
      .TASK_COUNT     (TASK_COUNT),
      .RESOURCE_COUNT (RESOURCE_COUNT),
      .UNIT_BITS      (UNIT_BITS)
   ) u_safety_scan (
      .clock       (clock),
      .reset       (reset),
      .launch      (scan_launch),
      .grant_task  (t_idx),
      .grant_res   (r_idx),
      .grant_units (u),
      .free_units  (free_ff),
      .retired     (retired_ff),
      .rd_en       (scan_rd_en),
      .rd_addr     (scan_rd_addr),
      .rd_claim    (rd_claim),
      .rd_held     (rd_held),
      .scan_stat   (scan_stat)
   );

   // result transaction
   assign busy      = (state_ff != SEQ_IDLE);
   assign rsp_valid = (state_ff == SEQ_REPLY);

   always_comb begin
      rsp_payload.status     = status_ff;
      rsp_payload.units_free = r_ok ? UNIT_W'(free_ff[r_idx]) : '0;
   end

endmodule
`default_nettype wire

// File: hw/rtl/bsra_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// bsra_checker
// Port-level checks of the allocator: every accepted transaction keeps the
// block busy until exactly one result strobe, which ends the busy period.
// -----------------------------------------------------------------------------
module bsra_checker (
   input wire clock,
   input wire reset,
   input wire start,
   input wire busy,
   input wire rsp_valid
);

   // an accepted transaction makes the block busy, with no result yet
   a_accept_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy && !rsp_valid))
      else $error("accepted transaction did not start a busy period");

   // results only appear inside a busy period
   a_strobe_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result strobe outside a busy period");

   // the result strobe ends the transaction
   a_strobe_ends_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> (!busy && !rsp_valid))
      else $error("busy period did not end after the result");

   // a busy period never ends without a result
   a_busy_ends_with_result: assert property (@(posedge clock) disable iff (reset)
      ($fell(busy) && !$past(reset)) |-> $past(rsp_valid))
      else $error("busy period ended without a result");

endmodule

bind bankers_safe_resource_allocator bsra_checker u_bsra_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid)
);
`default_nettype wire
